// ===== design/mck_pkg.sv =====
// mck_pkg: shared types, register codes and the character pattern table
// for the morse character keyer; no dependencies
package mck_pkg;

  localparam int TIME_W     = 10;
  localparam int SPACE_W    = 11;
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 3;
  localparam int PAT_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int NUM_CODES  = 36;
  localparam int CODE_IDX_W = 6;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DOT_TIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_GAP  = 2'd2;

  localparam logic [TIME_W-1:0] DOT_TIME_RST  = 10'd75;
  localparam logic [TIME_W-1:0] DASH_TIME_RST = 10'd200;
  localparam logic [TIME_W-1:0] CHAR_GAP_RST  = 10'd500;

  // element count per code, letters then digits
  localparam logic [LEN_W-1:0] MORSE_LEN [NUM_CODES] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  // bit k set: element k is a dash
  localparam logic [PAT_W-1:0] MORSE_PAT [NUM_CODES] = '{
    5'h02, 5'h01, 5'h05, 5'h01, 5'h00, 5'h04, 5'h03, 5'h00, 5'h00, 5'h0E,
    5'h05, 5'h02, 5'h03, 5'h01, 5'h07, 5'h06, 5'h0B, 5'h02, 5'h00, 5'h01,
    5'h04, 5'h08, 5'h06, 5'h09, 5'h0D, 5'h03,
    5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h10, 5'h00, 5'h01, 5'h03, 5'h07, 5'h0F
  };

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] pattern;
    logic             invalid;
  } mck_desc_t;

  typedef struct packed {
    logic [TIME_W-1:0] dot_time;
    logic [TIME_W-1:0] dash_time;
    logic [TIME_W-1:0] char_gap;
  } mck_timing_t;

  // fold case, map to table entry; no code gives a single invalid element
  function automatic mck_desc_t mck_classify(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0]     u;
    logic [CODE_IDX_W-1:0] idx;
    logic                  found;
    mck_desc_t             d;
    u     = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    idx   = '0;
    found = 1'b0;
    if (u >= 8'h41 && u <= 8'h5A) begin
      idx   = CODE_IDX_W'(u - 8'h41);
      found = 1'b1;
    end else if (u >= 8'h30 && u <= 8'h39) begin
      idx   = CODE_IDX_W'(u - 8'h30) + 6'd26;
      found = 1'b1;
    end
    if (found) begin
      d.len     = MORSE_LEN[idx];
      d.pattern = MORSE_PAT[idx];
      d.invalid = 1'b0;
    end else begin
      d.len     = 3'd1;
      d.pattern = '0;
      d.invalid = 1'b1;
    end
    return d;
  endfunction

endpackage

// ===== design/mck_char_if.sv =====
// mck_char_if: character channel, valid/ready with the ascii code
// depends on mck_pkg
interface mck_char_if import mck_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// ===== design/mck_elem_if.sv =====
// mck_elem_if: element channel, valid/ready with mark and space times
// depends on mck_pkg
interface mck_elem_if import mck_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  mark_time;
  logic [SPACE_W-1:0] space_time;
  logic               invalid_char;
  logic               last_element;

  modport source (output valid, output mark_time, output space_time,
                  output invalid_char, output last_element, input ready);
  modport sink   (input valid, input mark_time, input space_time,
                  input invalid_char, input last_element, output ready);
endinterface

// ===== design/mck_front.sv =====
// mck_front: takes characters and registers their pattern descriptor
// depends on mck_pkg and mck_char_if
module mck_front import mck_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  mck_char_if.sink      char_in,
  output logic          desc_valid,
  input  logic          desc_ready,
  output mck_desc_t     desc
);

  logic fv;

  assign char_in.ready = !fv || desc_ready;
  assign desc_valid    = fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (char_in.ready) begin
      fv <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      desc <= mck_classify(char_in.char_code);
    end
  end

endmodule

// ===== design/mck_queue.sv =====
// mck_queue: small descriptor fifo between front and back
// depends on mck_pkg
module mck_queue import mck_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  mck_desc_t push_desc,
  output logic      pop_valid,
  input  logic      pop_ready,
  output mck_desc_t pop_desc
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mck_desc_t          entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_desc   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

endmodule

// ===== design/mck_back.sv =====
// mck_back: steps through the elements of one descriptor, one per cycle while
// the output is not stalled, into the output register; depends on mck_pkg and mck_elem_if
module mck_back import mck_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mck_timing_t timing,
  input  logic        desc_valid,
  output logic        desc_ready,
  input  mck_desc_t   desc,
  mck_elem_if.source  elem_out
);

  logic               busy;
  mck_desc_t          cur;
  logic [LEN_W-1:0]   k;
  logic               ov;
  logic               advance;
  logic               is_last;
  logic               take;
  logic [TIME_W-1:0]  t;
  logic [SPACE_W-1:0] s;

  assign advance    = busy && (!ov || elem_out.ready);
  assign is_last    = (k == cur.len - 3'd1);
  assign desc_ready = !busy || (advance && is_last);
  assign take       = desc_valid && desc_ready;

  always_comb begin
    if (cur.invalid) begin
      t = '0;
    end else if (cur.pattern[k]) begin
      t = timing.dash_time;
    end else begin
      t = timing.dot_time;
    end
    s = {1'b0, t} + (is_last ? {1'b0, timing.char_gap} : SPACE_W'(0));
  end

  assign elem_out.valid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ov   <= 1'b0;
      k    <= '0;
    end else begin
      if (take) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (advance) begin
        if (is_last) begin
          busy <= 1'b0;
        end
        k <= k + 3'd1;
      end
      if (advance) begin
        ov <= 1'b1;
      end else if (elem_out.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= desc;
    end
    if (advance) begin
      elem_out.mark_time    <= t;
      elem_out.space_time   <= s;
      elem_out.invalid_char <= cur.invalid;
      elem_out.last_element <= is_last;
    end
  end

endmodule

// ===== design/morse_character_keyer.sv =====
// morse_character_keyer: top level, timing registers plus front, queue and back
// depends on mck_pkg, mck_char_if, mck_elem_if, mck_front, mck_queue, mck_back
//
//   channel    dir   carries                                          transfer when
//   char_in    in    char_code[7:0]                                   valid && ready
//   elem_out   out   mark_time[9:0] space_time[10:0] invalid_char     valid && ready
//                    last_element
//   cfg        in    cfg_wr_en cfg_index[1:0] cfg_data[9:0]           cfg_wr_en
//
// a character of n elements (n = 1..5) is stepped through by the back end, which
// emits one element per cycle while the output is not stalled; that element
// stepper sets the rate; the first element passes the front register, the queue,
// the back end's descriptor register and the output register
// rst is synchronous; it empties all stages and loads the timing defaults
// the front keeps taking characters while the back end or the output stalls,
// until the queue and front register are full
module morse_character_keyer import mck_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  mck_char_if.sink             char_in,
  mck_elem_if.source           elem_out,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  // timing registers, to be written by the user only while the keyer is idle; the block has no check for it
  mck_timing_t timing;

  // front to queue
  logic      f_valid;
  logic      f_ready;
  mck_desc_t f_desc;

  // queue to back
  logic      q_valid;
  logic      q_ready;
  mck_desc_t q_desc;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.dot_time  <= DOT_TIME_RST;
      timing.dash_time <= DASH_TIME_RST;
      timing.char_gap  <= CHAR_GAP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DOT_TIME:  timing.dot_time  <= cfg_data;
        REG_DASH_TIME: timing.dash_time <= cfg_data;
        REG_CHAR_GAP:  timing.char_gap  <= cfg_data;
        default:       ;  // unknown index ignored
      endcase
    end
  end

  // classify the character into length, dash mask and invalid flag
  mck_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_in),
    .desc_valid (f_valid),
    .desc_ready (f_ready),
    .desc       (f_desc)
  );

  // decouples classification from element stepping
  mck_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_desc  (f_desc),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_desc   (q_desc)
  );

  // turn each descriptor into its elements using the timing registers
  mck_back u_back (
    .clk        (clk),
    .rst        (rst),
    .timing     (timing),
    .desc_valid (q_valid),
    .desc_ready (q_ready),
    .desc       (q_desc),
    .elem_out   (elem_out)
  );

  // an invalid character is a single gap-only element
  a_invalid_shape: assert property (@(posedge clk) disable iff (rst)
    elem_out.valid && elem_out.invalid_char |->
      elem_out.last_element && elem_out.mark_time == '0)
    else $error("invalid character element is not a lone gap");

  // inner elements have equal on and off times
  a_inner_space: assert property (@(posedge clk) disable iff (rst)
    elem_out.valid && !elem_out.last_element |->
      elem_out.space_time == {1'b0, elem_out.mark_time})
    else $error("inner element space differs from mark");

  // a valid element keys for a dot or a dash length
  a_mark_is_timing: assert property (@(posedge clk) disable iff (rst)
    elem_out.valid && !elem_out.invalid_char |->
      elem_out.mark_time == timing.dot_time || elem_out.mark_time == timing.dash_time)
    else $error("mark time is neither dot nor dash time");

endmodule

// ===== tb/sv/morse_character_keyer_tb.sv =====
// morse_character_keyer_tb: self-checking bench for the morse character keyer;
// drives characters and timing writes, predicts every element and checks it
// depends on mck_pkg, mck_char_if, mck_elem_if and morse_character_keyer
module morse_character_keyer_tb;
  import mck_pkg::*;

  // register index that the keyer does not decode, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int NUM_TIMINGS     = 6;
  localparam int ITEMS_PER_SET   = 74;
  localparam int END_SLACK       = 8;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int NUM_PROBES      = 25;

  // one element as it leaves the keyer
  typedef struct packed {
    logic [TIME_W-1:0]  mark;
    logic [SPACE_W-1:0] space;
    logic               inv;
    logic               last;
  } keyer_elem_t;

  // directed row: typed rows give a single closing element spelt out in full,
  // the rest are left to the element predictor
  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    bit                 typed;
    logic [TIME_W-1:0]  mark;
    logic [SPACE_W-1:0] space;
    logic               inv;
  } probe_row_t;

  // run against the reset timing: dot 75, dash 200, gap 500
  localparam probe_row_t PROBES [NUM_PROBES] = '{
    // one-element letters, both cases
    '{"E",   1'b1, 10'd75,  11'd575, 1'b0},
    '{"T",   1'b1, 10'd200, 11'd700, 1'b0},
    '{"e",   1'b1, 10'd75,  11'd575, 1'b0},
    '{"t",   1'b1, 10'd200, 11'd700, 1'b0},
    // no code: code 0, all ones, and the neighbours of every valid range
    '{8'h00, 1'b1, 10'd0,   11'd500, 1'b1},
    '{8'hFF, 1'b1, 10'd0,   11'd500, 1'b1},
    '{8'h40, 1'b1, 10'd0,   11'd500, 1'b1},   // at sign, just below upper case
    '{8'h5B, 1'b1, 10'd0,   11'd500, 1'b1},   // open bracket, just above it
    '{8'h60, 1'b1, 10'd0,   11'd500, 1'b1},   // grave accent, below lower case
    '{8'h7B, 1'b1, 10'd0,   11'd500, 1'b1},   // open brace, above it
    '{8'h2F, 1'b1, 10'd0,   11'd500, 1'b1},   // slash, below the digits
    '{8'h3A, 1'b1, 10'd0,   11'd500, 1'b1},   // colon, above them
    '{8'h80, 1'b1, 10'd0,   11'd500, 1'b1},
    '{8'hC1, 1'b1, 10'd0,   11'd500, 1'b1},   // 'A' with the top bit set
    '{8'h20, 1'b1, 10'd0,   11'd500, 1'b1},   // blank
    // multi-element characters, ends of each range, the corrected N
    '{"A",   1'b0, 10'd0,   11'd0,   1'b0},
    '{"Z",   1'b0, 10'd0,   11'd0,   1'b0},
    '{"a",   1'b0, 10'd0,   11'd0,   1'b0},
    '{"z",   1'b0, 10'd0,   11'd0,   1'b0},
    '{"0",   1'b0, 10'd0,   11'd0,   1'b0},
    '{"9",   1'b0, 10'd0,   11'd0,   1'b0},
    '{"N",   1'b0, 10'd0,   11'd0,   1'b0},
    '{"n",   1'b0, 10'd0,   11'd0,   1'b0},
    '{"5",   1'b0, 10'd0,   11'd0,   1'b0},
    '{"Q",   1'b0, 10'd0,   11'd0,   1'b0}
  };

  // letters A-Z then digits 0-9, element k is character k of the string
  string morse_shapes [36] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIME_W-1:0]    cfg_data;

  mck_char_if char_ch ();
  mck_elem_if elem_ch ();

  morse_character_keyer dut (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_ch),
    .elem_out  (elem_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // bench copy of the timing registers
  logic [TIME_W-1:0] dot_ms;
  logic [TIME_W-1:0] dash_ms;
  logic [TIME_W-1:0] gap_ms;

  // elements still owed by the keyer, oldest first
  keyer_elem_t pending_elems [$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  logic [8:0]  rx_cyc      = '0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // work out the elements of one character under the current timing
  function automatic void predict_elements(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] u;
    int                idx;
    string             shape;
    logic [TIME_W-1:0] t;
    keyer_elem_t       e;
    u   = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    idx = -1;
    if (u >= "A" && u <= "Z") idx = int'(u - "A");
    else if (u >= "0" && u <= "9") idx = int'(u - "0") + 26;
    if (idx < 0) begin
      // no code: a gap-only element, flagged
      e.mark  = '0;
      e.space = SPACE_W'(gap_ms);
      e.inv   = 1'b1;
      e.last  = 1'b1;
      pending_elems.push_back(e);
    end else begin
      shape = morse_shapes[idx];
      for (int k = 0; k < shape.len(); k++) begin
        t       = (shape[k] == "-") ? dash_ms : dot_ms;
        e.last  = (k == shape.len() - 1);
        e.mark  = t;
        e.space = SPACE_W'(t) + (e.last ? SPACE_W'(gap_ms) : SPACE_W'(0));
        e.inv   = 1'b0;
        pending_elems.push_back(e);
      end
    end
  endfunction

  // mostly well-formed letters and digits, the rest any byte at all
  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned r;
    if ($urandom_range(0, 3) == 0) return CHAR_W'($urandom_range(0, 255));
    r = $urandom_range(0, 61);
    if (r < 26) return CHAR_W'("A" + r);
    if (r < 52) return CHAR_W'("a" + r - 26);
    return CHAR_W'("0" + r - 52);
  endfunction

  // present one character and hold it until the transfer edge
  task automatic send_char(input logic [CHAR_W-1:0] c);
    char_ch.valid     <= 1'b1;
    char_ch.char_code <= c;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending_elems.size() != 0) @(posedge clk);
  endtask

  // write all three timings plus a junk write to the spare index, back to back
  task automatic program_timing(input logic [TIME_W-1:0] dot, input logic [TIME_W-1:0] dash,
                                input logic [TIME_W-1:0] gap);
    logic [CFG_IDX_W-1:0] idx_l [4];
    logic [TIME_W-1:0]    val_l [4];
    idx_l = '{REG_DOT_TIME, REG_DASH_TIME, REG_CHAR_GAP, REG_SPARE};
    val_l = '{dot, dash, gap, TIME_W'($urandom_range(0, 1023))};
    for (int w = 0; w < 4; w++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx_l[w];
      cfg_data  <= val_l[w];
      @(posedge clk);
      case (idx_l[w])
        REG_DOT_TIME:  dot_ms  = val_l[w];
        REG_DASH_TIME: dash_ms = val_l[w];
        REG_CHAR_GAP:  gap_ms  = val_l[w];
        default: ;
      endcase
    end
    cfg_wr_en <= 1'b0;
  endtask

  // receiver: its own stall pattern, changing with the top two bits of its cycle counter
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 9'd1;
    case (rx_cyc[8:7])
      2'd0: elem_ch.ready <= 1'b1;
      2'd1: elem_ch.ready <= 1'($urandom_range(0, 1));
      2'd2: elem_ch.ready <= (rx_cyc[3:0] == 4'd0) || ($urandom_range(0, 7) == 0);
      default: elem_ch.ready <= (rx_cyc[2:0] != 3'd5);
    endcase
  end

  // element checker: every transfer against the oldest owed element
  always @(posedge clk) begin
    keyer_elem_t want;
    if (!rst && elem_ch.valid && elem_ch.ready) begin
      if (pending_elems.size() == 0) begin
        $error("element transfer with nothing owed: mark_time %0d space_time %0d",
               elem_ch.mark_time, elem_ch.space_time);
        fail_count++;
      end else begin
        want = pending_elems.pop_front();
        if (elem_ch.mark_time !== want.mark) begin
          $error("mark_time: expected %0d, got %0d", want.mark, elem_ch.mark_time);
          fail_count++;
        end
        if (elem_ch.space_time !== want.space) begin
          $error("space_time: expected %0d, got %0d", want.space, elem_ch.space_time);
          fail_count++;
        end
        if (elem_ch.invalid_char !== want.inv) begin
          $error("invalid_char: expected %0d, got %0d", want.inv, elem_ch.invalid_char);
          fail_count++;
        end
        if (elem_ch.last_element !== want.last) begin
          $error("last_element: expected %0d, got %0d", want.last, elem_ch.last_element);
          fail_count++;
        end
      end
    end
  end

  // watchdog, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("morse_character_keyer verification failed");
      $finish;
    end
  end

  initial begin
    logic [CHAR_W-1:0] c;
    logic [TIME_W-1:0] t_dot, t_dash, t_gap;
    int unsigned       burst_left;
    bit                held_off;
    held_off = 1'b0;

    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= REG_DOT_TIME;
    cfg_data          <= '0;
    char_ch.valid     <= 1'b0;
    char_ch.char_code <= '0;
    dot_ms  = DOT_TIME_RST;
    dash_ms = DASH_TIME_RST;
    gap_ms  = CHAR_GAP_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part: one unbroken burst under the reset timing
    foreach (PROBES[r]) begin
      send_char(PROBES[r].ch);
      if (PROBES[r].typed)
        pending_elems.push_back('{PROBES[r].mark, PROBES[r].space, PROBES[r].inv, 1'b1});
      else
        predict_elements(PROBES[r].ch);
    end
    char_ch.valid <= 1'b0;
    wait_idle();

    // random part: a new timing set per phase, written only once drained
    for (int p = 0; p < NUM_TIMINGS; p++) begin
      case (p)
        0: begin                        // shortest dot, longest dash and gap: space 2046
          t_dot = 10'd1; t_dash = 10'd1023; t_gap = 10'd1023;
        end
        1: begin
          t_dot = 10'd1023; t_dash = 10'd1; t_gap = 10'd0;
        end
        2: begin                        // zero times, below the legal range
          t_dot = 10'd0; t_dash = 10'd0; t_gap = 10'd0;
        end
        5: begin
          t_dot = 10'd1023; t_dash = 10'd1023; t_gap = 10'd1023;
        end
        default: begin
          t_dot  = TIME_W'($urandom_range(1, 1023));
          t_dash = TIME_W'($urandom_range(1, 1023));
          t_gap  = TIME_W'($urandom_range(0, 1023));
        end
      endcase
      program_timing(t_dot, t_dash, t_gap);

      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        c = pick_char();
        send_char(c);
        predict_elements(c);
        burst_left--;
        if (burst_left == 0 || i == ITEMS_PER_SET - 1) begin
          char_ch.valid <= 1'b0;
          if (!held_off && p == 1 && i >= ITEMS_PER_SET / 2) begin
            // hold the sender until the keyer has emptied completely
            wait_idle();
            @(posedge clk);
            held_off = 1'b1;
          end else begin
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
          // now and then a long burst with no gaps at all
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
        end
      end
      wait_idle();
    end

    // let any stray element show up before the verdict
    repeat (END_SLACK) @(posedge clk);
    if (fail_count == 0) begin
      $display("morse_character_keyer verification clean");
    end else begin
      $display("morse_character_keyer verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mck_pkg.sv
design/mck_char_if.sv
design/mck_elem_if.sv
design/mck_front.sv
design/mck_queue.sv
design/mck_back.sv
design/morse_character_keyer.sv
tb/sv/morse_character_keyer_tb.sv
